FILE: hdl/spa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spa_pkg: shared types and constants of the sparse polynomial adder
// Item formats, term store sizing and command codes used by the front,
// the back and the top level.
// ----------------------------------------------------------------------------
package spa_pkg;

  // term store depth and derived widths
  localparam int unsigned MAX_TERMS = 32;
  localparam int unsigned IDX_W     = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
  localparam int unsigned CNT_W     = $clog2(MAX_TERMS + 1);

  // command queue between front and back, depth is a power of two
  localparam int unsigned CMDQ_DEPTH = 2;
  localparam int unsigned CMDQ_PTR_W = (CMDQ_DEPTH > 1) ? $clog2(CMDQ_DEPTH) : 1;
  localparam int unsigned CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

  // input mode codes
  localparam logic [1:0] MODE_FIRST  = 2'd0;
  localparam logic [1:0] MODE_SECOND = 2'd1;
  localparam logic [1:0] MODE_FINISH = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef enum logic [1:0] {
    CMD_LOAD_FIRST  = 2'd0,
    CMD_LOAD_SECOND = 2'd1,
    CMD_FINISH      = 2'd2
  } cmd_e;

  typedef struct packed {
    logic [1:0]         mode;
    logic signed [31:0] coefficient;
    logic [15:0]        exponent;
  } in_item_t;

  typedef struct packed {
    logic signed [32:0] sum_coefficient;
    logic [15:0]        sum_exponent;
    logic               last_term;
    logic               empty_sum;
    logic               overflow;
  } out_item_t;

  typedef struct packed {
    logic signed [31:0] coef;
    logic [15:0]        expo;
  } term_t;

  localparam int unsigned TERM_W = $bits(term_t);

  typedef struct packed {
    cmd_e  kind;
    term_t term;
  } cmd_t;

  // handshake between front queue and back engine
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } cmd_chan_t;

endpackage

`default_nettype wire

FILE: hdl/spa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spa_ram: generic single write port RAM
// One write and one read per cycle, read data registered.
// ----------------------------------------------------------------------------
module spa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [ADDR_W-1:0]        waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic [ADDR_W-1:0]        raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: hdl/spa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spa_front: input side of the sparse polynomial adder
// Accepts items, decodes the mode into a command and queues it for the back.
// Items with the unused mode are accepted and discarded.
// ----------------------------------------------------------------------------
module spa_front (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              push,
  output logic                   full,
  input  wire spa_pkg::in_item_t in_item_i,
  output spa_pkg::cmd_chan_t     cmd_o,
  input  wire logic              cmd_take_i
);

  spa_pkg::cmd_t                     q_mem_q [spa_pkg::CMDQ_DEPTH];
  logic [spa_pkg::CMDQ_PTR_W-1:0]    wr_ptr_q, wr_ptr_d;
  logic [spa_pkg::CMDQ_PTR_W-1:0]    rd_ptr_q, rd_ptr_d;
  logic [spa_pkg::CMDQ_CNT_W-1:0]    cnt_q, cnt_d;
  logic                              accept;
  logic                              enq;
  logic                              deq;
  logic                              is_cmd;
  spa_pkg::cmd_t                     new_cmd;

  always_comb begin
    is_cmd        = 1'b1;
    new_cmd.kind  = spa_pkg::CMD_FINISH;
    new_cmd.term.coef = in_item_i.coefficient;
    new_cmd.term.expo = in_item_i.exponent;
    unique case (in_item_i.mode)
      spa_pkg::MODE_FIRST:  new_cmd.kind = spa_pkg::CMD_LOAD_FIRST;
      spa_pkg::MODE_SECOND: new_cmd.kind = spa_pkg::CMD_LOAD_SECOND;
      spa_pkg::MODE_FINISH: new_cmd.kind = spa_pkg::CMD_FINISH;
      default:              is_cmd = 1'b0;
    endcase
  end

  assign full   = (cnt_q == spa_pkg::CMDQ_CNT_W'(spa_pkg::CMDQ_DEPTH));
  assign accept = push && !full;
  assign enq    = accept && is_cmd;
  assign deq    = cmd_take_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = enq ? wr_ptr_q + spa_pkg::CMDQ_PTR_W'(1) : wr_ptr_q;
    rd_ptr_d = deq ? rd_ptr_q + spa_pkg::CMDQ_PTR_W'(1) : rd_ptr_q;
    cnt_d    = cnt_q;
    if (enq && !deq) begin
      cnt_d = cnt_q + spa_pkg::CMDQ_CNT_W'(1);
    end else if (deq && !enq) begin
      cnt_d = cnt_q - spa_pkg::CMDQ_CNT_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (enq) begin
      q_mem_q[wr_ptr_q] <= new_cmd;
    end
  end

  assign cmd_o.valid = (cnt_q != '0);
  assign cmd_o.cmd   = q_mem_q[rd_ptr_q];

endmodule

`default_nettype wire

FILE: hdl/spa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// spa_back: term stores and merge engine of the sparse polynomial adder
// Loads terms into two stores and, on finish, merges them by exponent into
// the result register, holding one term back so the final one can be marked.
// ----------------------------------------------------------------------------
module spa_back (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire spa_pkg::cmd_chan_t cmd_i,
  output logic                    cmd_take_o,
  output logic                    empty,
  input  wire logic               pop,
  output spa_pkg::out_item_t      out_item_o
);

  typedef enum logic [3:0] {
    S_IDLE  = 4'b0001,
    S_FETCH = 4'b0010,
    S_MERGE = 4'b0100,
    S_DONE  = 4'b1000
  } state_e;

  state_e                       state_q, state_d;
  logic [spa_pkg::CNT_W-1:0]    cnt_a_q, cnt_a_d, cnt_b_q, cnt_b_d;
  logic [spa_pkg::CNT_W-1:0]    i_q, i_d, j_q, j_d;
  logic                         dropped_q, dropped_d;
  logic                         pend_valid_q, pend_valid_d;
  spa_pkg::out_item_t           pend_q, pend_d;
  logic                         out_valid_q, out_valid_d;
  spa_pkg::out_item_t           out_q, out_d;

  logic                         we_a, we_b;
  logic [spa_pkg::TERM_W-1:0]   rd_a_raw, rd_b_raw;
  spa_pkg::term_t               rd_a, rd_b;

  logic                         out_slot;
  logic                         out_push;
  logic                         a_has, b_has;
  logic                         take_a, take_b, take_both;
  logic signed [32:0]           coef_a, coef_b, sum_ab;
  logic                         emit;
  spa_pkg::out_item_t           term_item;

  spa_ram #(
    .WIDTH (spa_pkg::TERM_W),
    .DEPTH (spa_pkg::MAX_TERMS)
  ) u_store_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (cnt_a_q[spa_pkg::IDX_W-1:0]),
    .wdata_i (cmd_i.cmd.term),
    .raddr_i (i_d[spa_pkg::IDX_W-1:0]),
    .rdata_o (rd_a_raw)
  );

  spa_ram #(
    .WIDTH (spa_pkg::TERM_W),
    .DEPTH (spa_pkg::MAX_TERMS)
  ) u_store_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (cnt_b_q[spa_pkg::IDX_W-1:0]),
    .wdata_i (cmd_i.cmd.term),
    .raddr_i (j_d[spa_pkg::IDX_W-1:0]),
    .rdata_o (rd_b_raw)
  );

  assign rd_a = spa_pkg::term_t'(rd_a_raw);
  assign rd_b = spa_pkg::term_t'(rd_b_raw);

  // merge step on the two head terms
  assign a_has     = (i_q < cnt_a_q);
  assign b_has     = (j_q < cnt_b_q);
  assign take_a    = a_has && (!b_has || (rd_a.expo > rd_b.expo));
  assign take_b    = b_has && (!a_has || (rd_b.expo > rd_a.expo));
  assign take_both = a_has && b_has && (rd_a.expo == rd_b.expo);
  assign coef_a    = {rd_a.coef[31], rd_a.coef};
  assign coef_b    = {rd_b.coef[31], rd_b.coef};
  assign sum_ab    = coef_a + coef_b;
  assign emit      = take_a || take_b || (take_both && (sum_ab != '0));

  always_comb begin
    term_item.sum_coefficient = take_a ? coef_a : (take_b ? coef_b : sum_ab);
    term_item.sum_exponent    = take_b ? rd_b.expo : rd_a.expo;
    term_item.last_term       = 1'b0;
    term_item.empty_sum       = 1'b0;
    term_item.overflow        = dropped_q;
  end

  assign out_slot = !out_valid_q || pop;

  always_comb begin
    state_d      = state_q;
    cnt_a_d      = cnt_a_q;
    cnt_b_d      = cnt_b_q;
    i_d          = i_q;
    j_d          = j_q;
    dropped_d    = dropped_q;
    pend_valid_d = pend_valid_q;
    pend_d       = pend_q;
    out_push     = 1'b0;
    out_d        = out_q;
    cmd_take_o   = 1'b0;
    we_a         = 1'b0;
    we_b         = 1'b0;

    unique case (state_q)
      S_IDLE: begin
        if (cmd_i.valid) begin
          cmd_take_o = 1'b1;
          unique case (cmd_i.cmd.kind)
            spa_pkg::CMD_LOAD_FIRST: begin
              if (cnt_a_q == spa_pkg::CNT_W'(spa_pkg::MAX_TERMS)) begin
                dropped_d = 1'b1;
              end else begin
                we_a    = 1'b1;
                cnt_a_d = cnt_a_q + spa_pkg::CNT_W'(1);
              end
            end
            spa_pkg::CMD_LOAD_SECOND: begin
              if (cnt_b_q == spa_pkg::CNT_W'(spa_pkg::MAX_TERMS)) begin
                dropped_d = 1'b1;
              end else begin
                we_b    = 1'b1;
                cnt_b_d = cnt_b_q + spa_pkg::CNT_W'(1);
              end
            end
            spa_pkg::CMD_FINISH: begin
              state_d = S_FETCH;
            end
            default: begin
            end
          endcase
        end
      end
      S_FETCH: begin
        // head entries are being read
        state_d = S_MERGE;
      end
      S_MERGE: begin
        if (!a_has && !b_has) begin
          state_d = S_DONE;
        end else if (!emit || !pend_valid_q || out_slot) begin
          i_d = i_q + spa_pkg::CNT_W'(take_a || take_both);
          j_d = j_q + spa_pkg::CNT_W'(take_b || take_both);
          if (emit) begin
            out_push     = pend_valid_q;
            out_d        = pend_q;
            pend_d       = term_item;
            pend_valid_d = 1'b1;
          end
        end
      end
      S_DONE: begin
        if (out_slot) begin
          out_push = 1'b1;
          if (pend_valid_q) begin
            out_d           = pend_q;
            out_d.last_term = 1'b1;
          end else begin
            out_d.sum_coefficient = '0;
            out_d.sum_exponent    = '0;
            out_d.last_term       = 1'b1;
            out_d.empty_sum       = 1'b1;
            out_d.overflow        = dropped_q;
          end
          pend_valid_d = 1'b0;
          cnt_a_d      = '0;
          cnt_b_d      = '0;
          dropped_d    = 1'b0;
          i_d          = '0;
          j_d          = '0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (out_push) begin
      out_valid_d = 1'b1;
    end else if (pop) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      cnt_a_q      <= '0;
      cnt_b_q      <= '0;
      i_q          <= '0;
      j_q          <= '0;
      dropped_q    <= 1'b0;
      pend_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      cnt_a_q      <= cnt_a_d;
      cnt_b_q      <= cnt_b_d;
      i_q          <= i_d;
      j_q          <= j_d;
      dropped_q    <= dropped_d;
      pend_valid_q <= pend_valid_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    pend_q <= pend_d;
    if (out_push) begin
      out_q <= out_d;
    end
  end

  assign empty      = !out_valid_q;
  assign out_item_o = out_q;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_a_q <= spa_pkg::CNT_W'(spa_pkg::MAX_TERMS)) &&
    (cnt_b_q <= spa_pkg::CNT_W'(spa_pkg::MAX_TERMS)))
    else $error("term count beyond store depth");

  a_idx_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (i_q <= cnt_a_q) && (j_q <= cnt_b_q))
    else $error("merge index past store count");

  a_no_push_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_IDLE || state_q == S_FETCH) |-> !out_push)
    else $error("result pushed outside merge");

  a_clear_after_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DONE && out_slot) |=>
      (cnt_a_q == '0 && cnt_b_q == '0 && !dropped_q && !pend_valid_q &&
       out_valid_q && out_q.last_term))
    else $error("stores not cleared after final item");
`endif

endmodule

`default_nettype wire

FILE: hdl/sparse_polynomial_adder.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// sparse_polynomial_adder: adds two sparse polynomials by exponent merge
// Input items (push/full) load terms of the first or second polynomial in
// descending exponent order, or finish the sum; the unused mode is dropped.
// Result items (empty/pop) give the sum terms in merge order, the final one
// with last_term set; an empty sum gives one item with empty_sum set. Terms
// loaded into a full store are dropped and reported by overflow on every
// result item of that sum.
// Loads are taken by the back engine while it is idle, so one term per
// cycle is sustained through the two-entry command queue. A finish item
// runs a fetch of the head entries, then one merge step per term pair or
// single term (one read port per store). The first result item enters the
// result register once a second term is emitted or the merge ends, which is
// later when leading terms cancel. Loads queued behind a finish wait until
// the final result item has entered the result register.
// Reset empties the command queue, both stores and the result register; no
// clearing pass is needed. When pop is held low the merge stops with one
// term in the result register and one held back, and full rises once the
// command queue fills.
// ----------------------------------------------------------------------------
module sparse_polynomial_adder (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push,
  output logic                    full,
  input  wire spa_pkg::in_item_t  in_item_i,
  output logic                    empty,
  input  wire logic               pop,
  output spa_pkg::out_item_t      out_item_o
);

  spa_pkg::cmd_chan_t cmd;
  logic               cmd_take;

  spa_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item_i),
    .cmd_o      (cmd),
    .cmd_take_i (cmd_take)
  );

  spa_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .cmd_take_o (cmd_take),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item_o)
  );

endmodule

`default_nettype wire

FILE: sim/tb_sparse_polynomial_adder.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sparse_polynomial_adder: self-checking bench for the sparse polynomial adder
// Loads terms into both stores, finishes each sum and checks every result
// term against an in-bench merge of the same stores. Directed sums cover the
// coefficient and exponent extremes, cancellation, zero terms, unsorted and
// repeated exponents, the unused mode and full stores; random sums follow,
// with bursts of idle cycles on both sides and a final stretch at full rate.
// ----------------------------------------------------------------------------
module tb_sparse_polynomial_adder;

  logic                clk_i   = 1'b0;
  logic                rst_ni  = 1'b0;
  logic                push    = 1'b0;
  logic                pop     = 1'b0;
  spa_pkg::in_item_t   in_item = '0;
  logic                full;
  logic                empty;
  spa_pkg::out_item_t  out_item;

  sparse_polynomial_adder uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push       (push),
    .full       (full),
    .in_item_i  (in_item),
    .empty      (empty),
    .pop        (pop),
    .out_item_o (out_item)
  );

  always #10 clk_i = ~clk_i;

  // bench copy of the two term stores
  logic [31:0] first_coef  [spa_pkg::MAX_TERMS];
  logic [15:0] first_expo  [spa_pkg::MAX_TERMS];
  logic [31:0] second_coef [spa_pkg::MAX_TERMS];
  logic [15:0] second_expo [spa_pkg::MAX_TERMS];
  int          first_cnt    = 0;
  int          second_cnt   = 0;
  logic        terms_lost   = 1'b0;

  spa_pkg::out_item_t expected_terms[$];
  spa_pkg::out_item_t want_term;
  int          errors      = 0;
  int          items_sent  = 0;
  bit          idle_on     = 1'b1;
  int          pop_hold    = 0;

  function automatic spa_pkg::in_item_t term_item(logic [1:0] mode, logic [31:0] c,
                                                  logic [15:0] e);
    spa_pkg::in_item_t it;
    it.mode        = mode;
    it.coefficient = c;
    it.exponent    = e;
    return it;
  endfunction

  function automatic logic [31:0] rand_coef();
    case ($urandom_range(0, 5))
      0: return 32'd0;
      1: return 32'($signed($urandom_range(0, 16)) - 8);
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      default: return $urandom;
    endcase
  endfunction

  // apply one accepted item to the bench stores, queue the sum terms on finish
  task automatic merge_stores(input spa_pkg::in_item_t it);
    spa_pkg::out_item_t sum_q[$];
    spa_pkg::out_item_t t;
    int                 i;
    int                 j;
    logic signed [32:0] s;
    i = 0;
    j = 0;
    case (it.mode)
      spa_pkg::MODE_FIRST: begin
        if (first_cnt < spa_pkg::MAX_TERMS) begin
          first_coef[first_cnt] = it.coefficient;
          first_expo[first_cnt] = it.exponent;
          first_cnt++;
        end else begin
          terms_lost = 1'b1;
        end
      end
      spa_pkg::MODE_SECOND: begin
        if (second_cnt < spa_pkg::MAX_TERMS) begin
          second_coef[second_cnt] = it.coefficient;
          second_expo[second_cnt] = it.exponent;
          second_cnt++;
        end else begin
          terms_lost = 1'b1;
        end
      end
      spa_pkg::MODE_FINISH: begin
        while (i < first_cnt || j < second_cnt) begin
          t          = '0;
          t.overflow = terms_lost;
          if (j >= second_cnt || (i < first_cnt && first_expo[i] > second_expo[j])) begin
            t.sum_coefficient = {first_coef[i][31], first_coef[i]};
            t.sum_exponent    = first_expo[i];
            sum_q.push_back(t);
            i++;
          end else if (i >= first_cnt || first_expo[i] < second_expo[j]) begin
            t.sum_coefficient = {second_coef[j][31], second_coef[j]};
            t.sum_exponent    = second_expo[j];
            sum_q.push_back(t);
            j++;
          end else begin
            // equal exponents add, a zero sum vanishes
            s = $signed({first_coef[i][31], first_coef[i]}) +
                $signed({second_coef[j][31], second_coef[j]});
            if (s != 0) begin
              t.sum_coefficient = s;
              t.sum_exponent    = first_expo[i];
              sum_q.push_back(t);
            end
            i++;
            j++;
          end
        end
        if (sum_q.size() == 0) begin
          t           = '0;
          t.empty_sum = 1'b1;
          t.overflow  = terms_lost;
          sum_q.push_back(t);
        end
        sum_q[sum_q.size() - 1].last_term = 1'b1;
        foreach (sum_q[k]) expected_terms.push_back(sum_q[k]);
        first_cnt  = 0;
        second_cnt = 0;
        terms_lost = 1'b0;
      end
      default: ;
    endcase
  endtask

  task automatic send_item(input spa_pkg::in_item_t it);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
    push    <= 1'b1;
    in_item <= it;
    @(posedge clk_i);
    while (full) @(posedge clk_i);
    merge_stores(it);
    items_sent++;
  endtask

  task automatic send_finish();
    send_item(term_item(spa_pkg::MODE_FINISH, $urandom, 16'($urandom)));
  endtask

  // result side: check each popped term, then pick pop for the next cycle
  always @(posedge clk_i) begin
    if (rst_ni && pop && !empty) begin
      if (expected_terms.size() == 0) begin
        $error("result item with no expectation waiting: coef %0d expo %0d",
               out_item.sum_coefficient, out_item.sum_exponent);
        errors++;
      end else begin
        want_term = expected_terms.pop_front();
        if (out_item.sum_coefficient !== want_term.sum_coefficient) begin
          $error("sum_coefficient expected %0d got %0d",
                 want_term.sum_coefficient, out_item.sum_coefficient);
          errors++;
        end
        if (out_item.sum_exponent !== want_term.sum_exponent) begin
          $error("sum_exponent expected %0d got %0d",
                 want_term.sum_exponent, out_item.sum_exponent);
          errors++;
        end
        if (out_item.last_term !== want_term.last_term) begin
          $error("last_term expected %0b got %0b", want_term.last_term, out_item.last_term);
          errors++;
        end
        if (out_item.empty_sum !== want_term.empty_sum) begin
          $error("empty_sum expected %0b got %0b", want_term.empty_sum, out_item.empty_sum);
          errors++;
        end
        if (out_item.overflow !== want_term.overflow) begin
          $error("overflow expected %0b got %0b", want_term.overflow, out_item.overflow);
          errors++;
        end
      end
    end
    if (!rst_ni) begin
      pop <= 1'b0;
    end else if (pop_hold > 0) begin
      pop_hold--;
      pop <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      pop_hold = $urandom_range(0, 4);
      pop <= 1'b0;
    end else begin
      pop <= 1'b1;
    end
  end

  // nothing loaded, then a pair that cancels; unused mode in between
  task automatic test_empty_sum();
    send_finish();
    send_item(term_item(spa_pkg::MODE_FIRST, 32'd9, 16'd3));
    send_item(term_item(spa_pkg::MODE_UNUSED, 32'hffff_ffff, 16'hffff));
    send_item(term_item(spa_pkg::MODE_SECOND, -32'sd9, 16'd3));
    send_finish();
  endtask

  task automatic test_extremes();
    send_item(term_item(spa_pkg::MODE_FIRST, 32'h7fff_ffff, 16'hffff));
    send_item(term_item(spa_pkg::MODE_SECOND, 32'h7fff_ffff, 16'hffff));
    send_item(term_item(spa_pkg::MODE_FIRST, 32'h8000_0000, 16'h0000));
    send_item(term_item(spa_pkg::MODE_SECOND, 32'h8000_0000, 16'h0000));
    send_finish();
  endtask

  // cancellation, zero coefficients kept or summed away
  task automatic test_cancel_and_zero();
    send_item(term_item(spa_pkg::MODE_FIRST, 32'd5, 16'd100));
    send_item(term_item(spa_pkg::MODE_SECOND, -32'sd5, 16'd100));
    send_item(term_item(spa_pkg::MODE_SECOND, 32'd3, 16'd60));
    send_item(term_item(spa_pkg::MODE_FIRST, 32'd0, 16'd50));
    send_item(term_item(spa_pkg::MODE_SECOND, 32'd0, 16'd50));
    send_item(term_item(spa_pkg::MODE_FIRST, 32'd7, 16'd10));
    send_item(term_item(spa_pkg::MODE_SECOND, 32'd0, 16'd10));
    send_item(term_item(spa_pkg::MODE_FIRST, 32'd0, 16'd5));
    send_finish();
  endtask

  task automatic test_unsorted();
    send_item(term_item(spa_pkg::MODE_FIRST, 32'd1, 16'd5));
    send_item(term_item(spa_pkg::MODE_FIRST, 32'd2, 16'd9));
    send_item(term_item(spa_pkg::MODE_UNUSED, 32'd0, 16'd0));
    send_item(term_item(spa_pkg::MODE_FIRST, 32'd3, 16'd9));
    send_item(term_item(spa_pkg::MODE_SECOND, 32'd4, 16'd9));
    send_item(term_item(spa_pkg::MODE_SECOND, 32'd5, 16'd2));
    send_finish();
  endtask

  // both stores overrun, every other second term sharing an exponent with the first
  task automatic test_store_full();
    for (int k = 0; k < spa_pkg::MAX_TERMS + 1; k++)
      send_item(term_item(spa_pkg::MODE_FIRST, rand_coef(), 16'(2 * (40 - k))));
    for (int k = 0; k < spa_pkg::MAX_TERMS + 2; k++)
      send_item(term_item(spa_pkg::MODE_SECOND, rand_coef(), 16'(2 * (40 - k) + k % 2)));
    send_finish();
  endtask

  // one random sum: a shared exponent walk, descending unless scrambled, split over the stores
  task automatic send_random_sum();
    spa_pkg::in_item_t first_q[$];
    spa_pkg::in_item_t second_q[$];
    int          n_expo;
    int          cur;
    bit          scrambled;
    logic [15:0] e;
    logic [31:0] c;
    n_expo    = ($urandom_range(0, 9) == 0) ? $urandom_range(36, 48) : $urandom_range(0, 10);
    scrambled = ($urandom_range(0, 7) == 0);
    cur       = $urandom_range(0, 65535);
    repeat (n_expo) begin
      e   = scrambled ? 16'($urandom) : 16'(cur);
      cur = cur - ($urandom_range(0, 1) ? $urandom_range(0, 3) : $urandom_range(0, 4000));
      if (cur < 0) cur = 0;
      c = rand_coef();
      case ($urandom_range(0, 3))
        0: first_q.push_back(term_item(spa_pkg::MODE_FIRST, c, e));
        1: second_q.push_back(term_item(spa_pkg::MODE_SECOND, c, e));
        2: begin
          first_q.push_back(term_item(spa_pkg::MODE_FIRST, c, e));
          second_q.push_back(term_item(spa_pkg::MODE_SECOND, rand_coef(), e));
        end
        default: begin
          first_q.push_back(term_item(spa_pkg::MODE_FIRST, c, e));
          second_q.push_back(term_item(spa_pkg::MODE_SECOND, -c, e));
        end
      endcase
    end
    while (first_q.size() != 0 || second_q.size() != 0) begin
      if ($urandom_range(0, 11) == 0)
        send_item(term_item(spa_pkg::MODE_UNUSED, $urandom, 16'($urandom)));
      else if (second_q.size() == 0 || (first_q.size() != 0 && $urandom_range(0, 1)))
        send_item(first_q.pop_front());
      else
        send_item(second_q.pop_front());
    end
    send_finish();
  endtask

  task automatic test_random_sums(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) send_random_sum();
  endtask

  task automatic test_full_rate(input int n_items);
    int stop_at;
    stop_at = items_sent + n_items;
    idle_on = 1'b0;
    while (items_sent < stop_at) send_random_sum();
  endtask

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_empty_sum();
    test_extremes();
    test_cancel_and_zero();
    test_unsorted();
    test_store_full();
    test_random_sums(200);
    test_full_rate(70);
    push <= 1'b0;
    while (expected_terms.size() != 0) @(posedge clk_i);
    repeat (80) @(posedge clk_i);
    if (errors == 0)
      $display("SUCCESS");
    else
      $display("FAILURE");
    $finish;
  end

  initial begin
    #20_000_000;
    $display("FAILURE");
    $finish;
  end

endmodule

FILE: filelist.f
hdl/spa_pkg.sv
hdl/spa_ram.sv
hdl/spa_front.sv
hdl/spa_back.sv
hdl/sparse_polynomial_adder.sv
sim/tb_sparse_polynomial_adder.sv
